@@ design/vms_pkg.sv @@
// ----------------------------------------------------------------------------
// vms_pkg
// Shared constants, codes and types of the vehicle mode supervisor.
// ----------------------------------------------------------------------------
package vms_pkg;

	// depth of the speed sample window
	localparam int SPEED_WINDOW = 8;
	localparam int WIN_AW = (SPEED_WINDOW > 1) ? $clog2(SPEED_WINDOW) : 1;
	localparam int WIN_CW = $clog2(SPEED_WINDOW + 1);

	localparam int CFG_IDX_W = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_ANGLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_DIST  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_SPEED   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_SETTLE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PLAN_SETTLE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ARRIVED_HOLD = 3'd5;

	typedef enum logic [2:0] {
		MODE_INIT        = 3'd0,
		MODE_WAIT_ROUTE  = 3'd1,
		MODE_PLAN        = 3'd2,
		MODE_WAIT_ENGAGE = 3'd3,
		MODE_DRIVE       = 3'd4,
		MODE_ARRIVED     = 3'd5,
		MODE_FINAL       = 3'd6
	} mode_t;

	// window scan status towards the sequencer
	typedef struct packed {
		logic done;
		logic stopped;
	} win_stat_t;

endpackage

@@ design/vms_ram.sv @@
// ----------------------------------------------------------------------------
// vms_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module vms_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/vms_window.sv @@
// ----------------------------------------------------------------------------
// vms_window
// Circular speed window in RAM: pushes one sample, then scans every entry
// and reports whether all magnitudes are at or below the stop limit.
// ----------------------------------------------------------------------------
module vms_window import vms_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic signed [15:0] speed,
	input  logic [15:0]        stop_limit,
	output win_stat_t          stat
);

	logic [WIN_AW-1:0]       wptr_q;
	logic [SPEED_WINDOW-1:0] valid_q;
	logic [WIN_CW-1:0]       cnt_q;
	logic                    scanning_q;
	logic                    slow_q;
	logic                    rd_pend_s1;
	logic                    rd_valid_s1;
	logic                    done_q;
	logic                    stopped_q;

	logic                    rd_en;
	logic [WIN_AW-1:0]       rd_addr;
	logic [15:0]             rd_data;
	logic [16:0]             rd_mag;
	logic                    rd_slow;

	assign rd_en   = scanning_q && (cnt_q < WIN_CW'(SPEED_WINDOW));
	assign rd_addr = cnt_q[WIN_AW-1:0];

	vms_ram #(
		.WIDTH (16),
		.DEPTH (SPEED_WINDOW),
		.AW    (WIN_AW)
	) u_ram (
		.clk   (clk),
		.we    (push),
		.waddr (wptr_q),
		.wdata (speed),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// never-written entries count as zero speed
	assign rd_mag  = rd_data[15] ? (17'h10000 - {1'b0, rd_data}) : {1'b0, rd_data};
	assign rd_slow = rd_pend_s1 && rd_valid_s1 && (rd_mag > {1'b0, stop_limit});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q      <= '0;
			valid_q     <= '0;
			cnt_q       <= '0;
			scanning_q  <= 1'b0;
			slow_q      <= 1'b0;
			rd_pend_s1  <= 1'b0;
			rd_valid_s1 <= 1'b0;
			done_q      <= 1'b0;
			stopped_q   <= 1'b0;
		end else begin
			done_q     <= 1'b0;
			rd_pend_s1 <= rd_en;
			if (rd_en) begin
				rd_valid_s1 <= valid_q[rd_addr];
			end
			if (push) begin
				valid_q[wptr_q] <= 1'b1;
				if (wptr_q == WIN_AW'(SPEED_WINDOW - 1)) begin
					wptr_q <= '0;
				end else begin
					wptr_q <= wptr_q + 1'b1;
				end
				scanning_q <= 1'b1;
				cnt_q      <= '0;
				slow_q     <= 1'b0;
			end else if (scanning_q) begin
				if (cnt_q == WIN_CW'(SPEED_WINDOW)) begin
					// last read data is judged in this cycle
					scanning_q <= 1'b0;
					done_q     <= 1'b1;
					stopped_q  <= !(slow_q || rd_slow);
				end else begin
					cnt_q  <= cnt_q + 1'b1;
					slow_q <= slow_q || rd_slow;
				end
			end
		end
	end

	assign stat.done    = done_q;
	assign stat.stopped = stopped_q;

endmodule

@@ design/vms_geom.sv @@
// ----------------------------------------------------------------------------
// vms_geom
// Three-stage pose check: squared distance to goal below the squared limit
// and wrapped yaw error below its limit.
// ----------------------------------------------------------------------------
module vms_geom import vms_pkg::*; (
	input  logic               clk,
	input  logic signed [23:0] pose_x,
	input  logic signed [23:0] pose_y,
	input  logic [15:0]        pose_yaw,
	input  logic signed [23:0] goal_x,
	input  logic signed [23:0] goal_y,
	input  logic [15:0]        goal_yaw,
	input  logic [15:0]        dist_limit,
	input  logic [15:0]        angle_limit,
	output logic               pose_ok
);

	logic signed [24:0] dx, dy;
	logic [24:0]        ax, ay;
	logic [15:0]        yd;
	logic [16:0]        ya;

	logic [15:0] mx_s1, my_s1, lim_s1;
	logic        far_s1, yaw_ok_s1;
	logic [31:0] sqx_s2, sqy_s2, lim2_s2;
	logic        far_s2, yaw_ok_s2;
	logic [32:0] d2;

	assign dx = 25'(pose_x) - 25'(goal_x);
	assign dy = 25'(pose_y) - 25'(goal_y);
	assign ax = dx[24] ? 25'(-dx) : 25'(dx);
	assign ay = dy[24] ? 25'(-dy) : 25'(dy);
	assign yd = pose_yaw - goal_yaw;
	assign ya = yd[15] ? (17'h10000 - {1'b0, yd}) : {1'b0, yd};

	// any axis error of 2^16 cm or more already exceeds the largest limit squared
	always_ff @(posedge clk) begin
		mx_s1     <= ax[15:0];
		my_s1     <= ay[15:0];
		far_s1    <= (ax[24:16] != '0) || (ay[24:16] != '0);
		yaw_ok_s1 <= ya < {1'b0, angle_limit};
		lim_s1    <= dist_limit;

		sqx_s2    <= mx_s1 * mx_s1;
		sqy_s2    <= my_s1 * my_s1;
		lim2_s2   <= lim_s1 * lim_s1;
		far_s2    <= far_s1;
		yaw_ok_s2 <= yaw_ok_s1;

		pose_ok   <= !far_s2 && yaw_ok_s2 && (d2 < {1'b0, lim2_s2});
	end

	assign d2 = {1'b0, sqx_s2} + {1'b0, sqy_s2};

endmodule

@@ design/vehicle_mode_supervisor_unit.sv @@
// ----------------------------------------------------------------------------
// vehicle_mode_supervisor_unit
// Seven-state vehicle mode supervisor with settle timers, route tracking and
// an arrival test over a RAM-held window of speed samples.
// ----------------------------------------------------------------------------
// Flow: an accepted item passes the push, window scan and decide states before
// its result is emitted, and the input stalls until then. The window scan reads
// one RAM entry per cycle through the single read port.
// Reset: asynchronous, mode initialising, registers at their defaults, the
// window reads as all zero through per-entry valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module vehicle_mode_supervisor_unit import vms_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [31:0]          now_ms,
	input  logic [6:0]           modules_ready,
	input  logic [15:0]          route_id,
	input  logic [3:0]           flags,
	input  logic signed [23:0]   pose_x,
	input  logic signed [23:0]   pose_y,
	input  logic [15:0]          pose_yaw,
	input  logic signed [23:0]   goal_x,
	input  logic signed [23:0]   goal_y,
	input  logic [15:0]          goal_yaw,
	input  logic signed [15:0]   speed,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [2:0]           mode_now,
	output logic                 mode_changed,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PUSH,
		ST_SCAN,
		ST_DECIDE
	} state_t;

	state_t state_q;

	// configuration
	logic [15:0] angle_lim_q, dist_lim_q, stop_lim_q;
	logic [15:0] init_settle_q, plan_settle_q, arrived_hold_q;

	// captured item
	logic [31:0]        now_q;
	logic [6:0]         ready_q;
	logic [15:0]        route_q;
	logic [3:0]         flags_q;
	logic signed [23:0] pose_x_q, pose_y_q, goal_x_q, goal_y_q;
	logic [15:0]        pose_yaw_q, goal_yaw_q;
	logic signed [15:0] speed_q;

	// supervisor state
	mode_t       mode_q;
	logic        init_wait_q, plan_wait_q;
	logic [31:0] init_time_q, plan_time_q, arrive_time_q;
	logic [15:0] active_route_q;
	logic        out_valid_q, changed_q;

	// next supervisor state for the item in hand
	mode_t       mode_nx;
	logic        init_wait_nx, plan_wait_nx;
	logic [31:0] init_time_nx, plan_time_nx, arrive_time_nx;
	logic [15:0] active_route_nx;

	logic      accept, push, pose_ok, arrived, engaged, new_route;
	logic      veh_ready, plan_ready, init_over, plan_over, hold_over, can_emit;
	logic      emit;
	win_stat_t win_st;

	assign cfg_ready    = 1'b1;
	assign in_stall     = (state_q != ST_IDLE);
	assign accept       = in_valid && !in_stall;
	assign push         = (state_q == ST_PUSH);
	assign out_valid    = out_valid_q;
	assign mode_now     = mode_q;
	assign mode_changed = changed_q;
	assign can_emit     = !out_valid_q || !out_stall;
	assign emit         = (state_q == ST_DECIDE) && can_emit;

	vms_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.speed      (speed_q),
		.stop_limit (stop_lim_q),
		.stat       (win_st)
	);

	vms_geom u_geom (
		.clk         (clk),
		.pose_x      (pose_x_q),
		.pose_y      (pose_y_q),
		.pose_yaw    (pose_yaw_q),
		.goal_x      (goal_x_q),
		.goal_y      (goal_y_q),
		.goal_yaw    (goal_yaw_q),
		.dist_limit  (dist_lim_q),
		.angle_limit (angle_lim_q),
		.pose_ok     (pose_ok)
	);

	assign arrived    = pose_ok && win_st.stopped;
	assign engaged    = flags_q[0] && flags_q[1];
	assign new_route  = (route_q != active_route_q);
	assign veh_ready  = (ready_q[4:0] == 5'h1F);
	assign plan_ready = ready_q[5] && ready_q[6];
	assign init_over  = (now_q - init_time_q) > {16'h0, init_settle_q};
	assign plan_over  = (now_q - plan_time_q) > {16'h0, plan_settle_q};
	assign hold_over  = (now_q - arrive_time_q) > {16'h0, arrived_hold_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_lim_q    <= 16'd4096;
			dist_lim_q     <= 16'd200;
			stop_lim_q     <= 16'd10;
			init_settle_q  <= 16'd1000;
			plan_settle_q  <= 16'd3000;
			arrived_hold_q <= 16'd2000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ARRIVE_ANGLE: angle_lim_q    <= cfg_data;
				REG_ARRIVE_DIST:  dist_lim_q     <= cfg_data;
				REG_STOP_SPEED:   stop_lim_q     <= cfg_data;
				REG_INIT_SETTLE:  init_settle_q  <= cfg_data;
				REG_PLAN_SETTLE:  plan_settle_q  <= cfg_data;
				REG_ARRIVED_HOLD: arrived_hold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_q      <= now_ms;
			ready_q    <= modules_ready;
			route_q    <= route_id;
			flags_q    <= flags;
			pose_x_q   <= pose_x;
			pose_y_q   <= pose_y;
			pose_yaw_q <= pose_yaw;
			goal_x_q   <= goal_x;
			goal_y_q   <= goal_y;
			goal_yaw_q <= goal_yaw;
			speed_q    <= speed;
		end
	end

	always_comb begin
		mode_nx         = mode_q;
		init_wait_nx    = init_wait_q;
		plan_wait_nx    = plan_wait_q;
		init_time_nx    = init_time_q;
		plan_time_nx    = plan_time_q;
		arrive_time_nx  = arrive_time_q;
		active_route_nx = active_route_q;
		if (flags_q[2]) begin
			mode_nx = MODE_FINAL;
		end else begin
			case (mode_q)
				MODE_INIT: begin
					if (veh_ready) begin
						if (!init_wait_q) begin
							init_wait_nx = 1'b1;
							init_time_nx = now_q;
						end else if (init_over) begin
							init_wait_nx = 1'b0;
							mode_nx      = MODE_WAIT_ROUTE;
						end
					end
				end
				MODE_WAIT_ROUTE: begin
					if (new_route) begin
						mode_nx = MODE_PLAN;
					end else if ((route_q != '0) && engaged && !arrived) begin
						mode_nx = MODE_DRIVE;
					end
				end
				MODE_PLAN: begin
					active_route_nx = route_q;
					if (plan_ready) begin
						if (!plan_wait_q) begin
							plan_wait_nx = 1'b1;
							plan_time_nx = now_q;
						end else if (plan_over) begin
							plan_wait_nx = 1'b0;
							mode_nx      = MODE_WAIT_ENGAGE;
						end
					end
				end
				MODE_WAIT_ENGAGE: begin
					if (flags_q[3]) begin
						mode_nx = MODE_WAIT_ROUTE;
					end else if (new_route) begin
						mode_nx = MODE_PLAN;
					end else if (engaged) begin
						mode_nx = MODE_DRIVE;
					end else if (arrived) begin
						arrive_time_nx = now_q;
						mode_nx        = MODE_ARRIVED;
					end
				end
				MODE_DRIVE: begin
					if (new_route) begin
						mode_nx = MODE_PLAN;
					end else if (!engaged) begin
						mode_nx = MODE_WAIT_ENGAGE;
					end else if (arrived) begin
						arrive_time_nx = now_q;
						mode_nx        = MODE_ARRIVED;
					end
				end
				MODE_ARRIVED: begin
					if (hold_over) begin
						mode_nx = MODE_WAIT_ROUTE;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			mode_q         <= MODE_INIT;
			init_wait_q    <= 1'b0;
			plan_wait_q    <= 1'b0;
			init_time_q    <= '0;
			plan_time_q    <= '0;
			arrive_time_q  <= '0;
			active_route_q <= '0;
			out_valid_q    <= 1'b0;
			changed_q      <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (win_st.done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (can_emit) begin
						state_q        <= ST_IDLE;
						changed_q      <= (mode_nx != mode_q);
						mode_q         <= mode_nx;
						init_wait_q    <= init_wait_nx;
						plan_wait_q    <= plan_wait_nx;
						init_time_q    <= init_time_nx;
						plan_time_q    <= plan_time_nx;
						arrive_time_q  <= arrive_time_nx;
						active_route_q <= active_route_nx;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ verif/tb_vehicle_mode_supervisor_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vehicle_mode_supervisor_unit
// Self-checking bench for the vehicle mode supervisor. Ticks go in through the
// valid/stall input channel, and a scoreboard predicts the mode and
// mode-changed bit of every accepted tick and checks each returned item in
// order. A short directed walk over the mode graph comes first. Phases of
// scenario-shaped random ticks follow, each with a fresh register setting and
// one of four idle patterns, and a short run with finalising ticks comes last.
// ----------------------------------------------------------------------------
module tb_vehicle_mode_supervisor_unit;
	import vms_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEMS_PER_PHASE = 88;
	localparam int NUM_PHASES = 6;

	localparam logic [3:0] FL_ENGAGE      = 4'h1;
	localparam logic [3:0] FL_AUTO        = 4'h2;
	localparam logic [3:0] FL_FINAL       = 4'h4;
	localparam logic [3:0] FL_ROUTE_RESET = 4'h8;
	localparam logic [3:0] FL_ENGAGED     = FL_ENGAGE | FL_AUTO;

	localparam logic [6:0] VEHICLE_READY  = 7'h1F;
	localparam logic [6:0] PLANNING_READY = 7'h60;
	localparam logic [6:0] ALL_READY      = 7'h7F;

	// indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct {
		logic [31:0]        now_ms;
		logic [6:0]         ready;
		logic [15:0]        route;
		logic [3:0]         flags;
		logic signed [23:0] px;
		logic signed [23:0] py;
		logic [15:0]        pyaw;
		logic signed [23:0] gx;
		logic signed [23:0] gy;
		logic [15:0]        gyaw;
		logic signed [15:0] spd;
	} tick_t;

	typedef struct {
		mode_t mode;
		bit    changed;
	} mode_rec_t;

	typedef enum {CFG_TYPICAL, CFG_ZERO, CFG_FULL, CFG_RANDOM} cfg_kind_t;
	typedef enum {ST_READY, ST_ROUTE, ST_DRIVE, ST_APPROACH, ST_HOLD} stage_t;

	class mode_scoreboard;
		logic [15:0]        angle_lim, dist_lim, stop_lim;
		logic [15:0]        init_settle, plan_settle, hold_ms;
		mode_t              mode;
		bit                 init_wait, plan_wait;
		logic [31:0]        init_stamp, plan_stamp, arrive_stamp;
		logic [15:0]        active_route;
		logic signed [15:0] speeds [SPEED_WINDOW];
		mode_rec_t          expected_q [$];
		int                 errors;

		function new();
			angle_lim = 16'd4096;
			dist_lim = 16'd200;
			stop_lim = 16'd10;
			init_settle = 16'd1000;
			plan_settle = 16'd3000;
			hold_ms = 16'd2000;
			mode = MODE_INIT;
			init_wait = 0;
			plan_wait = 0;
			init_stamp = '0;
			plan_stamp = '0;
			arrive_stamp = '0;
			active_route = '0;
			foreach (speeds[i]) speeds[i] = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
			case (idx)
				REG_ARRIVE_ANGLE: angle_lim = val;
				REG_ARRIVE_DIST:  dist_lim = val;
				REG_STOP_SPEED:   stop_lim = val;
				REG_INIT_SETTLE:  init_settle = val;
				REG_PLAN_SETTLE:  plan_settle = val;
				REG_ARRIVED_HOLD: hold_ms = val;
				default: ;
			endcase
		endfunction

		// modular ms difference strictly beyond the limit
		function bit settled(logic [31:0] now, logic [31:0] stamp, logic [15:0] lim);
			logic [31:0] diff;
			diff = now - stamp;
			return diff > {16'h0, lim};
		endfunction

		function bit at_goal(tick_t t);
			longint dx, dy, d2, l2;
			logic signed [15:0] ydiff;
			int ya, sa;
			dx = longint'(t.px) - longint'(t.gx);
			dy = longint'(t.py) - longint'(t.gy);
			d2 = dx * dx + dy * dy;
			l2 = longint'(dist_lim) * longint'(dist_lim);
			ydiff = t.pyaw - t.gyaw;
			ya = (ydiff < 0) ? -int'(ydiff) : int'(ydiff);
			if (!(d2 < l2) || !(ya < int'(angle_lim)))
				return 0;
			foreach (speeds[i]) begin
				sa = (speeds[i] < 0) ? -int'(speeds[i]) : int'(speeds[i]);
				if (sa > int'(stop_lim))
					return 0;
			end
			return 1;
		endfunction

		function void note_tick(tick_t t);
			mode_t nxt;
			bit engaged, fresh;
			mode_rec_t rec;
			for (int i = SPEED_WINDOW - 1; i > 0; i--)
				speeds[i] = speeds[i - 1];
			speeds[0] = t.spd;
			engaged = (t.flags & FL_ENGAGED) == FL_ENGAGED;
			fresh = t.route != active_route;
			nxt = mode;
			if ((t.flags & FL_FINAL) != 0) begin
				nxt = MODE_FINAL;
			end else begin
				case (mode)
					MODE_INIT: if ((t.ready & VEHICLE_READY) == VEHICLE_READY) begin
						if (!init_wait) begin
							init_wait = 1;
							init_stamp = t.now_ms;
						end else if (settled(t.now_ms, init_stamp, init_settle)) begin
							init_wait = 0;
							nxt = MODE_WAIT_ROUTE;
						end
					end
					MODE_WAIT_ROUTE: begin
						if (fresh)
							nxt = MODE_PLAN;
						else if (t.route != 0 && engaged && !at_goal(t))
							nxt = MODE_DRIVE;
					end
					MODE_PLAN: begin
						active_route = t.route;
						if ((t.ready & PLANNING_READY) == PLANNING_READY) begin
							if (!plan_wait) begin
								plan_wait = 1;
								plan_stamp = t.now_ms;
							end else if (settled(t.now_ms, plan_stamp, plan_settle)) begin
								plan_wait = 0;
								nxt = MODE_WAIT_ENGAGE;
							end
						end
					end
					MODE_WAIT_ENGAGE: begin
						if ((t.flags & FL_ROUTE_RESET) != 0)
							nxt = MODE_WAIT_ROUTE;
						else if (fresh)
							nxt = MODE_PLAN;
						else if (engaged)
							nxt = MODE_DRIVE;
						else if (at_goal(t)) begin
							arrive_stamp = t.now_ms;
							nxt = MODE_ARRIVED;
						end
					end
					MODE_DRIVE: begin
						if (fresh)
							nxt = MODE_PLAN;
						else if (!engaged)
							nxt = MODE_WAIT_ENGAGE;
						else if (at_goal(t)) begin
							arrive_stamp = t.now_ms;
							nxt = MODE_ARRIVED;
						end
					end
					MODE_ARRIVED: begin
						if (settled(t.now_ms, arrive_stamp, hold_ms))
							nxt = MODE_WAIT_ROUTE;
					end
					default: ;
				endcase
			end
			rec.mode = nxt;
			rec.changed = (nxt != mode);
			expected_q.insert(expected_q.size(), rec);
			mode = nxt;
		endfunction

		function void check_mode(logic [2:0] got_mode, logic got_changed);
			mode_rec_t exp;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected item, mode_now %0d mode_changed %0d",
					$time, got_mode, got_changed);
				return;
			end
			exp = expected_q.pop_front();
			if (got_mode !== exp.mode) begin
				errors++;
				$display("%0t: mode_now expected %0d got %0d", $time, exp.mode, got_mode);
			end
			if (got_changed !== exp.changed) begin
				errors++;
				$display("%0t: mode_changed expected %0d got %0d",
					$time, exp.changed, got_changed);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [31:0]          now_ms;
	logic [6:0]           modules_ready;
	logic [15:0]          route_id;
	logic [3:0]           flags;
	logic signed [23:0]   pose_x;
	logic signed [23:0]   pose_y;
	logic [15:0]          pose_yaw;
	logic signed [23:0]   goal_x;
	logic signed [23:0]   goal_y;
	logic [15:0]          goal_yaw;
	logic signed [15:0]   speed;
	logic                 out_valid;
	logic                 out_stall;
	logic [2:0]           mode_now;
	logic                 mode_changed;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_data;

	mode_scoreboard sb = new();

	int gap_pct = 0;
	int stall_pct = 0;
	bit hold_ask = 0;
	int cycle_count = 0;

	cfg_kind_t phase_kind [NUM_PHASES] =
		'{CFG_TYPICAL, CFG_ZERO, CFG_FULL, CFG_RANDOM, CFG_RANDOM, CFG_TYPICAL};
	int phase_gap [4] = '{0, 50, 0, 10};
	int phase_stall [4] = '{0, 0, 50, 10};

	// scenario generator state
	stage_t             stage = ST_HOLD;
	int                 stage_left = 0;
	int                 step_max = 1500;
	logic [31:0]        gen_ms = '0;
	logic [15:0]        gen_route = 16'd1;
	logic signed [23:0] gen_gx = '0;
	logic signed [23:0] gen_gy = '0;
	logic [15:0]        gen_gyaw = '0;

	vehicle_mode_supervisor_unit dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		tick_t seen;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				seen.now_ms = now_ms;
				seen.ready = modules_ready;
				seen.route = route_id;
				seen.flags = flags;
				seen.px = pose_x;
				seen.py = pose_y;
				seen.pyaw = pose_yaw;
				seen.gx = goal_x;
				seen.gy = goal_y;
				seen.gyaw = goal_yaw;
				seen.spd = speed;
				sb.note_tick(seen);
			end
			if (out_valid && !out_stall)
				sb.check_mode(mode_now, mode_changed);
		end
	end

	// receiver: random stall, or a long hold-off when asked
	initial begin
		int hold_left;
		bit hold_used;
		hold_left = 0;
		hold_used = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_ask && !hold_used) begin
				hold_used = 1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	function automatic int spread(int half);
		return int'($urandom_range(2 * half)) - half;
	endfunction

	function automatic logic signed [23:0] rand24();
		case ($urandom_range(3))
			0: return 24'sh800000;
			1: return 24'sh7FFFFF;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic tick_t mk(logic [31:0] n, logic [6:0] r, logic [15:0] rt,
			logic [3:0] f, logic signed [23:0] px, py, logic [15:0] pyw,
			logic signed [23:0] gx, gy, logic [15:0] gyw, logic signed [15:0] s);
		tick_t t;
		t.now_ms = n;
		t.ready = r;
		t.route = rt;
		t.flags = f;
		t.px = px;
		t.py = py;
		t.pyaw = pyw;
		t.gx = gx;
		t.gy = gy;
		t.gyaw = gyw;
		t.spd = s;
		return t;
	endfunction

	// walks ready -> new route -> drive -> approach -> hold, with noise mixed in
	function automatic tick_t next_tick();
		tick_t t;
		int dlim, nearby, far_off, slim;
		if (stage_left == 0) begin
			stage = (stage == ST_HOLD) ? ST_READY : stage_t'(stage + 1);
			case (stage)
				ST_READY:    stage_left = $urandom_range(5, 2);
				ST_ROUTE: begin
					stage_left = $urandom_range(6, 3);
					gen_route = 16'($urandom_range(65535, 1));
					gen_gx = 24'(spread(8000000));
					gen_gy = 24'(spread(8000000));
					gen_gyaw = 16'($urandom);
				end
				ST_DRIVE:    stage_left = $urandom_range(5, 2);
				ST_APPROACH: stage_left = $urandom_range(12, 9);
				default:     stage_left = $urandom_range(6, 3);
			endcase
		end
		stage_left--;
		dlim = int'(sb.dist_lim);
		nearby = dlim / 3;
		far_off = dlim + 1000 + int'($urandom_range(60000));
		slim = (sb.stop_lim > 16'd32767) ? 32767 : int'(sb.stop_lim);
		gen_ms += $urandom_range(step_max);
		t.now_ms = gen_ms;
		t.ready = ALL_READY;
		t.route = gen_route;
		t.flags = '0;
		t.gx = gen_gx;
		t.gy = gen_gy;
		t.gyaw = gen_gyaw;
		t.px = 24'(gen_gx + ($urandom_range(1) ? far_off : -far_off));
		t.py = 24'(gen_gy + spread(nearby));
		t.pyaw = 16'(gen_gyaw + spread(int'(sb.angle_lim) / 2));
		t.spd = 16'(spread(slim));
		case (stage)
			ST_READY: begin
				if ($urandom_range(3) == 0)
					t.ready = 7'($urandom);
			end
			ST_ROUTE: begin
				if ($urandom_range(4) == 0)
					t.ready = 7'($urandom);
				t.spd = 16'($urandom);
			end
			ST_DRIVE: begin
				t.flags = FL_ENGAGED;
				t.spd = 16'($urandom);
			end
			ST_APPROACH: begin
				t.flags = FL_ENGAGED;
				t.px = 24'(gen_gx + spread(nearby));
			end
			default: begin
				t.flags = 4'($urandom_range(15)) & ~FL_FINAL;
				if ($urandom_range(1))
					t.px = 24'(gen_gx + spread(nearby));
			end
		endcase
		if ($urandom_range(99) < 12) begin
			t.ready = 7'($urandom);
			t.flags = 4'($urandom_range(15)) & ~FL_FINAL;
			t.px = rand24();
			t.py = rand24();
			t.pyaw = 16'($urandom);
			t.gx = rand24();
			t.gy = rand24();
			t.gyaw = 16'($urandom);
			case ($urandom_range(3))
				0: t.spd = 16'sh8000;
				1: t.spd = 16'sh7FFF;
				default: t.spd = 16'($urandom);
			endcase
			if ($urandom_range(2) == 0)
				t.route = $urandom_range(3) ? 16'($urandom) : 16'h0;
			if ($urandom_range(3) == 0)
				t.now_ms = $urandom;
		end
		return t;
	endfunction

	task automatic send_tick(input tick_t t);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		now_ms <= t.now_ms;
		modules_ready <= t.ready;
		route_id <= t.route;
		flags <= t.flags;
		pose_x <= t.px;
		pose_y <= t.py;
		pose_yaw <= t.pyaw;
		goal_x <= t.gx;
		goal_y <= t.gy;
		goal_yaw <= t.gyaw;
		speed <= t.spd;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (sb.expected_q.size() != 0) @(negedge clk);
	endtask

	task automatic configure(input cfg_kind_t kind, input int ph);
		logic [15:0] v [6];
		int longest;
		case (kind)
			CFG_ZERO: foreach (v[i]) v[i] = '0;
			CFG_FULL: begin
				foreach (v[i]) v[i] = 16'hFFFF;
				v[0] = 16'd32768;
			end
			CFG_RANDOM: begin
				foreach (v[i]) v[i] = 16'($urandom);
				v[0] = 16'($urandom_range(32768));
			end
			default: begin
				v[0] = 16'($urandom_range(8192, 1024));
				v[1] = 16'($urandom_range(2000, 200));
				v[2] = 16'($urandom_range(200, 10));
				v[3] = 16'($urandom_range(1500, 50));
				v[4] = 16'($urandom_range(1500, 50));
				v[5] = 16'($urandom_range(1500, 50));
			end
		endcase
		write_reg(REG_ARRIVE_ANGLE, v[0]);
		write_reg(REG_ARRIVE_DIST, v[1]);
		write_reg(REG_STOP_SPEED, v[2]);
		write_reg(REG_INIT_SETTLE, v[3]);
		write_reg(REG_PLAN_SETTLE, v[4]);
		write_reg(REG_ARRIVED_HOLD, v[5]);
		// nothing lives here; the write must leave every register alone
		write_reg(ph[0] ? REG_SPARE_HI : REG_SPARE_LO, 16'($urandom));
		cfg_valid <= 1'b0;
		longest = int'(v[3]);
		if (int'(v[4]) > longest) longest = int'(v[4]);
		if (int'(v[5]) > longest) longest = int'(v[5]);
		step_max = longest * 2 / 3 + 4;
	endtask

	initial begin
		tick_t t;
		arst_n = 1'b0;
		in_valid = 1'b0;
		now_ms = '0;
		modules_ready = '0;
		route_id = '0;
		flags = '0;
		pose_x = '0;
		pose_y = '0;
		pose_yaw = '0;
		goal_x = '0;
		goal_y = '0;
		goal_yaw = '0;
		speed = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed walk at reset settings
		send_tick(mk(0, 7'h00, 16'h0, 4'h0, 0, 0, 0, 0, 0, 0, 0));
		send_tick(mk(32'hFFFF_FFFF, 7'h1E, 16'hFFFF, 4'hB, 24'sh7FFFFF, 24'sh800000,
			16'hFFFF, 24'sh800000, 24'sh7FFFFF, 16'h0, 16'sh8000));
		send_tick(mk(100, VEHICLE_READY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// readiness drops while the settle wait is pending
		send_tick(mk(1100, 7'h00, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_tick(mk(1100, VEHICLE_READY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_tick(mk(1101, ALL_READY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_tick(mk(1200, ALL_READY, 0, FL_ENGAGED, 5000, 0, 0, 0, 0, 0, 0));
		send_tick(mk(1300, ALL_READY, 16'h0001, 0, 5000, 0, 0, 0, 0, 0, 0));
		send_tick(mk(1400, VEHICLE_READY, 16'h0001, 0, 5000, 0, 0, 0, 0, 0, 0));
		send_tick(mk(1500, PLANNING_READY, 16'h0001, 0, 5000, 0, 0, 0, 0, 0, 3));
		send_tick(mk(4500, PLANNING_READY, 16'hFFFF, 0, 5000, 0, 0, 0, 0, 0, -3));
		send_tick(mk(4501, ALL_READY, 16'hFFFF, 0, 5000, 0, 0, 0, 0, 0, 0));
		send_tick(mk(4600, ALL_READY, 16'hFFFF, FL_ROUTE_RESET, 0, 0, 0, 0, 0, 0, 0));
		// same route, engaged, exactly at the distance limit: drives off
		send_tick(mk(4700, ALL_READY, 16'hFFFF, FL_ENGAGED, 200, 0, 0, 0, 0, 0, 0));
		send_tick(mk(4800, ALL_READY, 16'hFFFF, FL_ENGAGE, 200, 0, 0, 0, 0, 0, 10));
		send_tick(mk(4900, ALL_READY, 16'hFFFF, 0, 7, -9, 4095, 7, -9, 0, -10));
		send_tick(mk(6900, ALL_READY, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0));
		send_tick(mk(6901, ALL_READY, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0));
		// half a turn of yaw error does not count as arrived at the reset angle limit
		send_tick(mk(7000, ALL_READY, 16'hFFFF, FL_ENGAGED, 0, 0, 0, 0, 0, 16'h8000, 0));
		send_tick(mk(7100, ALL_READY, 16'hFFFF, FL_ENGAGED, 0, 0, 0, 0, 0, 4095, 11));
		send_tick(mk(7200, ALL_READY, 16'hFFFF, FL_ENGAGED, 0, 0, 0, 0, 0, 0, 0));
		send_tick(mk(7300, ALL_READY, 16'h0002, FL_ENGAGED, 0, 0, 0, 0, 0, 0, 0));
		in_valid <= 1'b0;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drained();
			gap_pct = 0;
			stall_pct = 0;
			configure(phase_kind[ph], ph);
			gen_ms = ph[0] ? 32'hFFFF_FFFF - $urandom_range(20000) : $urandom;
			gap_pct = phase_gap[ph % 4];
			stall_pct = phase_stall[ph % 4];
			if (ph == 4)
				hold_ask = 1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_tick(next_tick());
			in_valid <= 1'b0;
		end

		// finalising is sticky until reset, so it comes last
		gap_pct = 10;
		for (int n = 0; n < 5; n++) begin
			t = next_tick();
			if (n == 0 || n == 4)
				t.flags = (n == 0) ? FL_FINAL : 4'hF;
			send_tick(t);
		end
		in_valid <= 1'b0;

		wait_drained();
		repeat (2 * (SPEED_WINDOW + 4)) @(negedge clk);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
